// ===== rtl/arsl_pkg.sv =====
// Package for the auto-repeat speed-limit stepper.
// Holds register indexes, reset values, the repeat phase type and control structs.
// No dependencies; every other file takes names from here by scope.
package arsl_pkg;

  localparam int unsigned NUM_REGS    = 8;
  localparam int unsigned NUM_BUTTONS = 4;
  localparam int unsigned REG_W       = 16;
  localparam int unsigned IDX_W       = $clog2(NUM_REGS);
  localparam int unsigned TIME_W      = 32;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LINEAR_STEP      = 3'd0;
  localparam logic [IDX_W-1:0] REG_LINEAR_CEILING   = 3'd1;
  localparam logic [IDX_W-1:0] REG_LINEAR_START     = 3'd2;
  localparam logic [IDX_W-1:0] REG_ANGULAR_STEP     = 3'd3;
  localparam logic [IDX_W-1:0] REG_ANGULAR_CEILING  = 3'd4;
  localparam logic [IDX_W-1:0] REG_ANGULAR_START    = 3'd5;
  localparam logic [IDX_W-1:0] REG_REPEAT_DELAY_MS  = 3'd6;
  localparam logic [IDX_W-1:0] REG_REPEAT_PERIOD_MS = 3'd7;

  // Reset values, in register index order
  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    16'd100, 16'd3000, 16'd300, 16'd500, 16'd3000, 16'd500, 16'd400, 16'd100
  };

  // Button positions in the fire mask
  localparam int unsigned BTN_LINEAR_UP    = 0;
  localparam int unsigned BTN_LINEAR_DOWN  = 1;
  localparam int unsigned BTN_ANGULAR_UP   = 2;
  localparam int unsigned BTN_ANGULAR_DOWN = 3;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_FIRST    = 2'd1,
    PH_REPEAT   = 2'd2
  } phase_t;

  // Timing thresholds shared by all repeat filters
  typedef struct packed {
    logic [REG_W-1:0] delay_ms;
    logic [REG_W-1:0] period_ms;
  } repeat_cfg_t;

  // Per-axis control for the limit stepper
  typedef struct packed {
    logic en;
    logic up;
    logic down;
    logic reload;
  } limit_ctl_t;

endpackage

// ===== rtl/arsl_tick_if.sv =====
// Channel interface for one control tick beat.
// Depends on arsl_pkg for the time width.
interface arsl_tick_if;
  logic                          valid;
  logic                          ready;
  logic [arsl_pkg::TIME_W-1:0]   now_ms;
  logic                          active;
  logic                          linear_up;
  logic                          linear_down;
  logic                          angular_up;
  logic                          angular_down;

  modport source (
    output valid, now_ms, active, linear_up, linear_down, angular_up, angular_down,
    input  ready
  );
  modport sink (
    input  valid, now_ms, active, linear_up, linear_down, angular_up, angular_down,
    output ready
  );
endinterface

// ===== rtl/arsl_result_if.sv =====
// Channel interface for one result beat: both limits and the fire mask.
// Depends on arsl_pkg for widths.
interface arsl_result_if;
  logic                              valid;
  logic                              ready;
  logic [arsl_pkg::REG_W-1:0]        linear_cap;
  logic [arsl_pkg::REG_W-1:0]        angular_cap;
  logic [arsl_pkg::NUM_BUTTONS-1:0]  fired_mask;

  modport source (
    output valid, linear_cap, angular_cap, fired_mask,
    input  ready
  );
  modport sink (
    input  valid, linear_cap, angular_cap, fired_mask,
    output ready
  );
endinterface

// ===== rtl/arsl_repeat_filter.sv =====
// Typematic repeat filter for one button: phase state and last firing time.
// Depends on arsl_pkg (phase_t, repeat_cfg_t, widths).
module arsl_repeat_filter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         pressed,
  input  logic [arsl_pkg::TIME_W-1:0]  now_ms,
  input  arsl_pkg::repeat_cfg_t        timing,
  output logic                         fire
);

  arsl_pkg::phase_t                phase;
  arsl_pkg::phase_t                phase_next;
  logic [arsl_pkg::TIME_W-1:0]     press_time;
  logic [arsl_pkg::TIME_W-1:0]     elapsed;
  logic [arsl_pkg::REG_W-1:0]      threshold;
  logic                            expired;

  // Elapsed time wraps modulo 2^32; equal to the threshold does not fire
  assign elapsed   = now_ms - press_time;
  assign threshold = (phase == arsl_pkg::PH_FIRST) ? timing.delay_ms : timing.period_ms;
  assign expired   = elapsed > {{(arsl_pkg::TIME_W-arsl_pkg::REG_W){1'b0}}, threshold};

  // Fire on a fresh press or once the hold time has run out
  always_comb begin
    fire = 1'b0;
    if (pressed) begin
      unique case (phase)
        arsl_pkg::PH_RELEASED: fire = 1'b1;
        arsl_pkg::PH_FIRST:    fire = expired;
        arsl_pkg::PH_REPEAT:   fire = expired;
        default:               fire = expired;
      endcase
    end
  end

  // Advance phase: release drops back, each firing moves forward
  always_comb begin
    phase_next = phase;
    if (!pressed) begin
      phase_next = arsl_pkg::PH_RELEASED;
    end else if (fire) begin
      unique case (phase)
        arsl_pkg::PH_RELEASED: phase_next = arsl_pkg::PH_FIRST;
        arsl_pkg::PH_FIRST:    phase_next = arsl_pkg::PH_REPEAT;
        arsl_pkg::PH_REPEAT:   phase_next = arsl_pkg::PH_REPEAT;
        default:               phase_next = arsl_pkg::PH_REPEAT;
      endcase
    end
  end

  // Hold state unless a tick is taken while active
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= arsl_pkg::PH_RELEASED;
      press_time <= '0;
    end else if (en) begin
      phase <= phase_next;
      if (fire) begin
        press_time <= now_ms;
      end
    end
  end

endmodule

// ===== rtl/arsl_limit_step.sv =====
// Speed limit register for one axis: step up/down and clamp to 0..ceiling.
// Depends on arsl_pkg (limit_ctl_t, widths).
module arsl_limit_step (
  input  logic                        clk,
  input  logic                        rst,
  input  arsl_pkg::limit_ctl_t        ctl,
  input  logic [arsl_pkg::REG_W-1:0]  step,
  input  logic [arsl_pkg::REG_W-1:0]  ceiling,
  input  logic [arsl_pkg::REG_W-1:0]  start,
  input  logic [arsl_pkg::REG_W-1:0]  init_value,
  output logic [arsl_pkg::REG_W-1:0]  limit_next
);

  localparam int unsigned SUM_W = arsl_pkg::REG_W + 2;

  logic        [arsl_pkg::REG_W-1:0] limit;
  logic signed [SUM_W-1:0]           up_term;
  logic signed [SUM_W-1:0]           down_term;
  logic signed [SUM_W-1:0]           sum;
  logic signed [SUM_W-1:0]           ceil_s;
  logic        [arsl_pkg::REG_W-1:0] clamped;

  // Add, subtract, then clamp once
  assign up_term   = ctl.up   ? signed'({2'b00, step}) : '0;
  assign down_term = ctl.down ? signed'({2'b00, step}) : '0;
  assign sum       = signed'({2'b00, limit}) + up_term - down_term;
  assign ceil_s    = signed'({2'b00, ceiling});

  always_comb begin
    priority if (sum <= 0) begin
      clamped = '0;
    end else if (sum >= ceil_s) begin
      clamped = ceiling;
    end else begin
      clamped = sum[arsl_pkg::REG_W-1:0];
    end
  end

  assign limit_next = ctl.en ? clamped : limit;

  // Reload on any register write, otherwise step on an active tick
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= init_value;
    end else if (ctl.reload) begin
      limit <= start;
    end else if (ctl.en) begin
      limit <= clamped;
    end
  end

endmodule

// ===== rtl/auto_repeat_speed_limit_stepper_unit.sv =====
// Top level of the auto-repeat speed-limit stepper: registers, tick stage, result stage.
// Depends on arsl_pkg, arsl_tick_if, arsl_result_if, arsl_repeat_filter, arsl_limit_step.
//
//   channel  | dir | beat contents
//   ---------+-----+------------------------------------------------------------
//   tick     | in  | now_ms, active, linear_up/down, angular_up/down
//   result   | out | linear_cap, angular_cap, fired_mask
//   cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One tick accepted per cycle while tick.ready is high; its result passes the
// tick register, then the result register, before it is offered.
// Filter and limit state update as the tick leaves the tick register, so ticks
// follow each other with no gap. A stalled result register holds both stages;
// tick.ready drops only while both stages are full and the result is not taken.
// Reset (synchronous) restores register defaults and reloads both limits.
module auto_repeat_speed_limit_stepper_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [arsl_pkg::IDX_W-1:0]        cfg_index,
  input  logic [arsl_pkg::REG_W-1:0]        cfg_data,
  arsl_tick_if.sink                         tick,
  arsl_result_if.source                     result
);

  logic [arsl_pkg::REG_W-1:0]        cfg_regs [arsl_pkg::NUM_REGS];
  logic [arsl_pkg::REG_W-1:0]        linear_start;
  logic [arsl_pkg::REG_W-1:0]        angular_start;
  arsl_pkg::repeat_cfg_t             timing;

  logic                              s1_valid;
  logic [arsl_pkg::TIME_W-1:0]       s1_now_ms;
  logic                              s1_active;
  logic [arsl_pkg::NUM_BUTTONS-1:0]  s1_buttons;
  logic                              advance;
  logic                              step_en;
  logic [arsl_pkg::NUM_BUTTONS-1:0]  fire;
  logic [arsl_pkg::NUM_BUTTONS-1:0]  fired;

  arsl_pkg::limit_ctl_t              lin_ctl;
  arsl_pkg::limit_ctl_t              ang_ctl;
  logic [arsl_pkg::REG_W-1:0]        lin_next;
  logic [arsl_pkg::REG_W-1:0]        ang_next;

  logic                              out_valid;
  logic [arsl_pkg::REG_W-1:0]        out_linear;
  logic [arsl_pkg::REG_W-1:0]        out_angular;
  logic [arsl_pkg::NUM_BUTTONS-1:0]  out_fired;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < arsl_pkg::NUM_REGS; i++) begin
        cfg_regs[i] <= arsl_pkg::REG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // Reload sees a start value written in the same beat
  assign linear_start  = (cfg_we && cfg_index == arsl_pkg::REG_LINEAR_START)
                         ? cfg_data : cfg_regs[arsl_pkg::REG_LINEAR_START];
  assign angular_start = (cfg_we && cfg_index == arsl_pkg::REG_ANGULAR_START)
                         ? cfg_data : cfg_regs[arsl_pkg::REG_ANGULAR_START];
  assign timing.delay_ms  = cfg_regs[arsl_pkg::REG_REPEAT_DELAY_MS];
  assign timing.period_ms = cfg_regs[arsl_pkg::REG_REPEAT_PERIOD_MS];

  // Handshake: move the tick stage on when the result stage is free
  assign advance    = s1_valid && (!out_valid || result.ready);
  assign tick.ready = !s1_valid || advance;
  assign step_en    = advance && s1_active;

  // Tick register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_now_ms  <= tick.now_ms;
      s1_active  <= tick.active;
      s1_buttons <= {tick.angular_down, tick.angular_up, tick.linear_down, tick.linear_up};
    end
  end

  // One repeat filter per button
  for (genvar b = 0; b < arsl_pkg::NUM_BUTTONS; b++) begin : g_btn
    arsl_repeat_filter u_filter (
      .clk     (clk),
      .rst     (rst),
      .en      (step_en),
      .pressed (s1_buttons[b]),
      .now_ms  (s1_now_ms),
      .timing  (timing),
      .fire    (fire[b])
    );
  end

  assign fired = s1_active ? fire : '0;

  // Per-axis limit steppers
  assign lin_ctl.en     = step_en;
  assign lin_ctl.up     = fire[arsl_pkg::BTN_LINEAR_UP];
  assign lin_ctl.down   = fire[arsl_pkg::BTN_LINEAR_DOWN];
  assign lin_ctl.reload = cfg_we;
  assign ang_ctl.en     = step_en;
  assign ang_ctl.up     = fire[arsl_pkg::BTN_ANGULAR_UP];
  assign ang_ctl.down   = fire[arsl_pkg::BTN_ANGULAR_DOWN];
  assign ang_ctl.reload = cfg_we;

  arsl_limit_step u_linear (
    .clk        (clk),
    .rst        (rst),
    .ctl        (lin_ctl),
    .step       (cfg_regs[arsl_pkg::REG_LINEAR_STEP]),
    .ceiling    (cfg_regs[arsl_pkg::REG_LINEAR_CEILING]),
    .start      (linear_start),
    .init_value (arsl_pkg::REG_RESET[arsl_pkg::REG_LINEAR_START]),
    .limit_next (lin_next)
  );

  arsl_limit_step u_angular (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ang_ctl),
    .step       (cfg_regs[arsl_pkg::REG_ANGULAR_STEP]),
    .ceiling    (cfg_regs[arsl_pkg::REG_ANGULAR_CEILING]),
    .start      (angular_start),
    .init_value (arsl_pkg::REG_RESET[arsl_pkg::REG_ANGULAR_START]),
    .limit_next (ang_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_linear  <= lin_next;
      out_angular <= ang_next;
      out_fired   <= fired;
    end
  end

  assign result.valid       = out_valid;
  assign result.linear_cap  = out_linear;
  assign result.angular_cap = out_angular;
  assign result.fired_mask  = out_fired;

endmodule

// ===== rtl/arsl_checker.sv =====
// Port-level checker for the speed-limit stepper, bound to the top level.
// Depends on arsl_pkg for widths.
module arsl_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_we,
  input logic                              tick_ready,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic [arsl_pkg::REG_W-1:0]        linear_cap,
  input logic [arsl_pkg::REG_W-1:0]        angular_cap,
  input logic [arsl_pkg::NUM_BUTTONS-1:0]  fired_mask
);

  logic                        have_last;
  logic                        cfg_seen;
  logic [arsl_pkg::REG_W-1:0]  last_linear;
  logic [arsl_pkg::REG_W-1:0]  last_angular;
  logic                        out_beat;

  assign out_beat = result_valid && result_ready;

  // Track the last delivered limits and any register write since
  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
      cfg_seen  <= 1'b0;
    end else if (out_beat) begin
      have_last <= 1'b1;
      cfg_seen  <= cfg_we;
    end else if (cfg_we) begin
      cfg_seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      last_linear  <= linear_cap;
      last_angular <= angular_cap;
    end
  end

  // A stalled result holds its beat
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(linear_cap)
      && $stable(angular_cap) && $stable(fired_mask))
    else $error("result beat changed while stalled");

  // Free output side always lets a tick in
  a_ready_path: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> tick_ready)
    else $error("tick blocked while result side ready");

  // No linear firing and no write: linear limit never rises
  a_linear_hold: assert property (@(posedge clk) disable iff (rst)
    out_beat && have_last && !cfg_seen && !cfg_we
      && fired_mask[arsl_pkg::BTN_LINEAR_UP] == 1'b0
      && fired_mask[arsl_pkg::BTN_LINEAR_DOWN] == 1'b0
      |-> linear_cap == last_linear || linear_cap <= last_linear)
    else $error("linear limit rose without a firing");

  // No angular firing and no write: angular limit never rises
  a_angular_hold: assert property (@(posedge clk) disable iff (rst)
    out_beat && have_last && !cfg_seen && !cfg_we
      && fired_mask[arsl_pkg::BTN_ANGULAR_UP] == 1'b0
      && fired_mask[arsl_pkg::BTN_ANGULAR_DOWN] == 1'b0
      |-> angular_cap <= last_angular)
    else $error("angular limit rose without a firing");

endmodule

bind auto_repeat_speed_limit_stepper_unit arsl_checker u_arsl_checker (
  .clk           (clk),
  .rst           (rst),
  .cfg_we        (cfg_we),
  .tick_ready    (tick.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .linear_cap    (result.linear_cap),
  .angular_cap   (result.angular_cap),
  .fired_mask    (result.fired_mask)
);

// ===== tb/arsl_limit_monitor.sv =====
// Checker for the auto-repeat speed-limit stepper: watches the tick, result and register ports.
// It predicts each result beat from its own model and compares it with what the block returns.
// Depends on arsl_pkg, arsl_tick_if and arsl_result_if.
module arsl_limit_monitor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [arsl_pkg::IDX_W-1:0] cfg_index,
  input  logic [arsl_pkg::REG_W-1:0] cfg_data,
  arsl_tick_if                       tick,
  arsl_result_if                     result,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REG_BITS  = arsl_pkg::REG_W;
  localparam int unsigned TIME_BITS = arsl_pkg::TIME_W;
  localparam int unsigned BTN_BITS  = arsl_pkg::NUM_BUTTONS;

  typedef struct {
    logic [REG_BITS-1:0] linear_cap;
    logic [REG_BITS-1:0] angular_cap;
    logic [BTN_BITS-1:0] fired_mask;
  } limits_t;

  // Model state: register copy, both limits, per-button repeat state
  logic [REG_BITS-1:0]  regs_now [arsl_pkg::NUM_REGS];
  logic [REG_BITS-1:0]  linear_now;
  logic [REG_BITS-1:0]  angular_now;
  arsl_pkg::phase_t     phase [arsl_pkg::NUM_BUTTONS];
  logic [TIME_BITS-1:0] last_fire [arsl_pkg::NUM_BUTTONS];
  limits_t              expected_limits [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Typematic filter of one button; updates its phase and firing time
  function automatic logic repeat_fires(int unsigned b, logic pressed,
                                        logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] elapsed;
    elapsed = now - last_fire[b];
    if (!pressed) begin
      phase[b] = arsl_pkg::PH_RELEASED;
      return 1'b0;
    end
    case (phase[b])
      arsl_pkg::PH_RELEASED: begin
        last_fire[b] = now;
        phase[b]     = arsl_pkg::PH_FIRST;
        return 1'b1;
      end
      arsl_pkg::PH_FIRST: begin
        if (elapsed <= TIME_BITS'(regs_now[arsl_pkg::REG_REPEAT_DELAY_MS])) return 1'b0;
        phase[b]     = arsl_pkg::PH_REPEAT;
        last_fire[b] = now;
        return 1'b1;
      end
      default: begin
        if (elapsed <= TIME_BITS'(regs_now[arsl_pkg::REG_REPEAT_PERIOD_MS])) return 1'b0;
        last_fire[b] = now;
        return 1'b1;
      end
    endcase
  endfunction

  // Add, subtract, then clamp once to 0..ceiling
  function automatic logic [REG_BITS-1:0] stepped_limit(logic [REG_BITS-1:0] cur, logic up,
                                                         logic down, logic [REG_BITS-1:0] step,
                                                         logic [REG_BITS-1:0] ceiling);
    int v;
    int s;
    int c;
    v = int'(cur);
    s = int'(step);
    c = int'(ceiling);
    if (up) v = v + s;
    if (down) v = v - s;
    if (v >= c) v = c;
    if (v <= 0) v = 0;
    return REG_BITS'(v);
  endfunction

  always @(posedge clk) begin : watch
    limits_t             want;
    logic [BTN_BITS-1:0] fire;
    logic [BTN_BITS-1:0] pressed;
    if (rst) begin
      // Restore register defaults and release every button
      for (int i = 0; i < arsl_pkg::NUM_REGS; i++) regs_now[i] = arsl_pkg::REG_RESET[i];
      for (int b = 0; b < arsl_pkg::NUM_BUTTONS; b++) begin
        phase[b]     = arsl_pkg::PH_RELEASED;
        last_fire[b] = '0;
      end
      linear_now  = arsl_pkg::REG_RESET[arsl_pkg::REG_LINEAR_START];
      angular_now = arsl_pkg::REG_RESET[arsl_pkg::REG_ANGULAR_START];
      expected_limits.delete();
    end else begin
      // Register write reloads both limits, repeat state is kept
      if (cfg_we) begin
        regs_now[cfg_index] = cfg_data;
        linear_now          = regs_now[arsl_pkg::REG_LINEAR_START];
        angular_now         = regs_now[arsl_pkg::REG_ANGULAR_START];
      end

      // Compare a returned beat with the oldest prediction
      if (result.valid && result.ready) begin
        if (expected_limits.size() == 0) begin
          $display("%0t: result beat with none expected: linear %0d angular %0d mask %b",
                   $time, result.linear_cap, result.angular_cap, result.fired_mask);
          errors++;
        end else begin
          want = expected_limits.pop_front();
          if (result.linear_cap !== want.linear_cap) begin
            $display("%0t: linear limit expected %0d actual %0d",
                     $time, want.linear_cap, result.linear_cap);
            errors++;
          end
          if (result.angular_cap !== want.angular_cap) begin
            $display("%0t: angular limit expected %0d actual %0d",
                     $time, want.angular_cap, result.angular_cap);
            errors++;
          end
          if (result.fired_mask !== want.fired_mask) begin
            $display("%0t: fired_mask expected %b actual %b",
                     $time, want.fired_mask, result.fired_mask);
            errors++;
          end
        end
      end

      // Predict the result of an accepted tick beat
      if (tick.valid && tick.ready) begin
        fire = '0;
        pressed[arsl_pkg::BTN_LINEAR_UP]    = tick.linear_up;
        pressed[arsl_pkg::BTN_LINEAR_DOWN]  = tick.linear_down;
        pressed[arsl_pkg::BTN_ANGULAR_UP]   = tick.angular_up;
        pressed[arsl_pkg::BTN_ANGULAR_DOWN] = tick.angular_down;
        if (tick.active) begin
          for (int b = 0; b < arsl_pkg::NUM_BUTTONS; b++) begin
            fire[b] = repeat_fires(b, pressed[b], tick.now_ms);
          end
          linear_now  = stepped_limit(linear_now, fire[arsl_pkg::BTN_LINEAR_UP],
                                      fire[arsl_pkg::BTN_LINEAR_DOWN],
                                      regs_now[arsl_pkg::REG_LINEAR_STEP],
                                      regs_now[arsl_pkg::REG_LINEAR_CEILING]);
          angular_now = stepped_limit(angular_now, fire[arsl_pkg::BTN_ANGULAR_UP],
                                      fire[arsl_pkg::BTN_ANGULAR_DOWN],
                                      regs_now[arsl_pkg::REG_ANGULAR_STEP],
                                      regs_now[arsl_pkg::REG_ANGULAR_CEILING]);
        end
        want.linear_cap  = linear_now;
        want.angular_cap = angular_now;
        want.fired_mask  = fire;
        expected_limits.push_back(want);
      end
    end
    pending = expected_limits.size();
  end

endmodule

// ===== tb/auto_repeat_speed_limit_stepper_unit_test.sv =====
// Top of the stepper testbench: clock, reset, tick and register stimulus, verdict.
// Depends on arsl_pkg, the channel interfaces, the block and arsl_limit_monitor.
module auto_repeat_speed_limit_stepper_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REG_BITS  = arsl_pkg::REG_W;
  localparam int unsigned IDX_BITS  = arsl_pkg::IDX_W;
  localparam int unsigned TIME_BITS = arsl_pkg::TIME_W;
  localparam int unsigned BTN_BITS  = arsl_pkg::NUM_BUTTONS;

  localparam logic [BTN_BITS-1:0] PRESS_NONE = '0;
  localparam logic [BTN_BITS-1:0] PRESS_LU   = BTN_BITS'(1 << arsl_pkg::BTN_LINEAR_UP);
  localparam logic [BTN_BITS-1:0] PRESS_LD   = BTN_BITS'(1 << arsl_pkg::BTN_LINEAR_DOWN);
  localparam logic [BTN_BITS-1:0] PRESS_AU   = BTN_BITS'(1 << arsl_pkg::BTN_ANGULAR_UP);
  localparam logic [BTN_BITS-1:0] PRESS_AD   = BTN_BITS'(1 << arsl_pkg::BTN_ANGULAR_DOWN);
  localparam logic [BTN_BITS-1:0] PRESS_ALL  = '1;
  localparam int PHASES          = 8;
  localparam int TICKS_PER_PHASE = 200;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [IDX_BITS-1:0] cfg_index;
  logic [REG_BITS-1:0] cfg_data;
  int                  errors;
  int                  pending;
  bit                  calm;

  logic [REG_BITS-1:0]  cfg_now [arsl_pkg::NUM_REGS];
  logic [TIME_BITS-1:0] clock_ms;
  logic [BTN_BITS-1:0]  held;

  arsl_tick_if   tick ();
  arsl_result_if result ();

  auto_repeat_speed_limit_stepper_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick),
    .result    (result)
  );

  arsl_limit_monitor u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick),
    .result    (result),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stall the result side at random, except in calm stretches
  always @(posedge clk) begin
    result.ready <= calm || ($urandom_range(99) >= 35);
  end

  // Drive one tick beat after a random gap and hold it until accepted
  task automatic send_tick(input logic [TIME_BITS-1:0] now, input logic act,
                           input logic [BTN_BITS-1:0] btn);
    while (!calm && $urandom_range(99) < 35) begin
      tick.valid <= 1'b0;
      @(posedge clk);
    end
    tick.valid        <= 1'b1;
    tick.now_ms       <= now;
    tick.active       <= act;
    tick.linear_up    <= btn[arsl_pkg::BTN_LINEAR_UP];
    tick.linear_down  <= btn[arsl_pkg::BTN_LINEAR_DOWN];
    tick.angular_up   <= btn[arsl_pkg::BTN_ANGULAR_UP];
    tick.angular_down <= btn[arsl_pkg::BTN_ANGULAR_DOWN];
    do @(posedge clk); while (!tick.ready);
  endtask

  // Drain outstanding results, then write every register from cfg_now
  task automatic load_registers();
    tick.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < arsl_pkg::NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= IDX_BITS'(i);
      cfg_data  <= cfg_now[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly held buttons with slowly advancing time, some noise beats
  task automatic random_ticks(input int count);
    int                  span;
    logic [BTN_BITS-1:0] btn;
    logic                act;
    span = int'(cfg_now[arsl_pkg::REG_REPEAT_DELAY_MS]);
    if (int'(cfg_now[arsl_pkg::REG_REPEAT_PERIOD_MS]) > span) begin
      span = int'(cfg_now[arsl_pkg::REG_REPEAT_PERIOD_MS]);
    end
    span = span / 3 + 3;
    repeat (count) begin
      if ($urandom_range(99) < 5) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, span);
      if ($urandom_range(99) < 10) begin
        btn = BTN_BITS'($urandom());
        act = 1'($urandom_range(1));
      end else begin
        for (int b = 0; b < arsl_pkg::NUM_BUTTONS; b++) begin
          if ($urandom_range(99) < 8) held[b] = ~held[b];
        end
        btn = held;
        act = ($urandom_range(99) < 92);
      end
      send_tick(clock_ms, act, btn);
    end
  endtask

  initial begin : stimulus
    tick.valid        = 1'b0;
    tick.now_ms       = '0;
    tick.active       = 1'b0;
    tick.linear_up    = 1'b0;
    tick.linear_down  = 1'b0;
    tick.angular_up   = 1'b0;
    tick.angular_down = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    calm              = 1'b0;
    held              = '0;
    clock_ms          = 32'hFFFF_F000;
    cfg_now           = arsl_pkg::REG_RESET;
    rst               = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Inactive tick freezes everything
    send_tick(32'd10, 1'b0, PRESS_ALL);
    // Fresh press, delay boundary, period boundary
    send_tick(32'd1000, 1'b1, PRESS_LU);
    send_tick(32'd1400, 1'b1, PRESS_LU);
    send_tick(32'd1401, 1'b1, PRESS_LU);
    send_tick(32'd1501, 1'b1, PRESS_LU);
    send_tick(32'd1502, 1'b1, PRESS_LU);
    send_tick(32'd1503, 1'b1, PRESS_LU | PRESS_LD);
    send_tick(32'd1504, 1'b1, PRESS_NONE);
    // Both buttons of each pair fire together
    send_tick(32'd1505, 1'b1, PRESS_ALL);
    send_tick(32'd1506, 1'b1, PRESS_NONE);
    // Hold angular up into the ceiling
    send_tick(32'd2000, 1'b1, PRESS_AU);
    send_tick(32'd2401, 1'b1, PRESS_AU);
    send_tick(32'd2502, 1'b1, PRESS_AU);
    send_tick(32'd2603, 1'b1, PRESS_AU);
    send_tick(32'd2704, 1'b1, PRESS_AU);
    send_tick(32'd2805, 1'b1, PRESS_AU);
    // Held button across the timestamp wrap
    send_tick(32'hFFFF_FF00, 1'b1, PRESS_AD);
    send_tick(32'h0000_0091, 1'b1, PRESS_AD);
    // Hold linear down to the floor
    for (int i = 0; i < 8; i++) send_tick(32'd5000 + 500 * i, 1'b1, PRESS_LD);

    // Start values above the ceilings: unclamped until the first active tick
    cfg_now[arsl_pkg::REG_LINEAR_START]    = 16'd5000;
    cfg_now[arsl_pkg::REG_ANGULAR_CEILING] = 16'd200;
    cfg_now[arsl_pkg::REG_ANGULAR_START]   = 16'd60000;
    load_registers();
    send_tick(32'd9000, 1'b0, PRESS_NONE);
    send_tick(32'd9001, 1'b1, PRESS_NONE);

    // Random phases over several register settings
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 4);
      case (p)
        0: cfg_now = arsl_pkg::REG_RESET;
        1: for (int i = 0; i < arsl_pkg::NUM_REGS; i++) cfg_now[i] = '0;
        2: for (int i = 0; i < arsl_pkg::NUM_REGS; i++) cfg_now[i] = '1;
        3: begin
          cfg_now[arsl_pkg::REG_LINEAR_STEP]      = 16'd300;
          cfg_now[arsl_pkg::REG_LINEAR_CEILING]   = 16'd1000;
          cfg_now[arsl_pkg::REG_LINEAR_START]     = 16'd60000;
          cfg_now[arsl_pkg::REG_ANGULAR_STEP]     = 16'd7;
          cfg_now[arsl_pkg::REG_ANGULAR_CEILING]  = 16'd20;
          cfg_now[arsl_pkg::REG_ANGULAR_START]    = 16'd65535;
          cfg_now[arsl_pkg::REG_REPEAT_DELAY_MS]  = 16'd5;
          cfg_now[arsl_pkg::REG_REPEAT_PERIOD_MS] = 16'd2;
        end
        default: begin
          cfg_now[arsl_pkg::REG_LINEAR_STEP]      = REG_BITS'($urandom_range(0, 3000));
          cfg_now[arsl_pkg::REG_LINEAR_CEILING]   = REG_BITS'($urandom());
          cfg_now[arsl_pkg::REG_LINEAR_START]     = REG_BITS'($urandom());
          cfg_now[arsl_pkg::REG_ANGULAR_STEP]     = (p == 7) ? REG_BITS'($urandom())
                                                    : REG_BITS'($urandom_range(0, 3000));
          cfg_now[arsl_pkg::REG_ANGULAR_CEILING]  = REG_BITS'($urandom());
          cfg_now[arsl_pkg::REG_ANGULAR_START]    = REG_BITS'($urandom());
          cfg_now[arsl_pkg::REG_REPEAT_DELAY_MS]  = REG_BITS'($urandom_range(0, 40));
          cfg_now[arsl_pkg::REG_REPEAT_PERIOD_MS] = REG_BITS'($urandom_range(0, 20));
        end
      endcase
      load_registers();
      random_ticks(TICKS_PER_PHASE);
    end
    calm = 1'b0;

    // Drain and give the verdict
    tick.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/arsl_pkg.sv
rtl/arsl_tick_if.sv
rtl/arsl_result_if.sv
rtl/arsl_repeat_filter.sv
rtl/arsl_limit_step.sv
rtl/auto_repeat_speed_limit_stepper_unit.sv
rtl/arsl_checker.sv
tb/arsl_limit_monitor.sv
tb/auto_repeat_speed_limit_stepper_unit_test.sv
